// File: design/multi_key_row_comparator_assert.svh
// Assertion macros shared by the checker of the multi-key row comparator.
// Depends on nothing; included by the checker file.
`ifndef MULTI_KEY_ROW_COMPARATOR_ASSERT_SVH
`define MULTI_KEY_ROW_COMPARATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MKRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define MKRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: design/mkrc_pkg.sv
// Package of the multi-key row comparator: key type codes, widths, defaults.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mkrc_pkg;
	localparam int KEY_W      = 64;
	localparam int DEF_MAX_KEYS = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [2:0] {
		KT_I32 = 3'd0, KT_U32 = 3'd1, KT_I64 = 3'd2, KT_U64 = 3'd3,
		KT_F32 = 3'd4, KT_F64 = 3'd5, KT_VTX = 3'd6, KT_RAW = 3'd7
	} key_type_t;

	typedef enum logic [1:0] {
		CFG_TYPES = 2'd0, CFG_DESC = 2'd1, CFG_COUNT = 2'd2, CFG_NONE = 2'd3
	} cfg_reg_t;

	// Per-lane outcome handed to the merge stage.
	typedef struct packed {
		logic lt;
		logic gt;
	} lane_res_t;
endpackage
`default_nettype wire

// File: design/multi_key_row_comparator.sv
// Top level of the multi-key row comparator: config registers, lanes, merge,
// output register. Depends on mkrc_pkg, mkrc_lane and mkrc_merge.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata: left a..d, right a..d (512 b)
// m_axis   out  tvalid/tready          tdata: left_first, all_equal, deciding_key
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The result of a row pair is registered in the output register at the edge
// that transfers the pair; one pair per cycle while the output is not stalled.
// The output register reloads whenever it is empty or being taken, so input
// stalls only while a result waits unaccepted. Reset clears the valid flag
// and the configuration to its defaults.
`timescale 1ns / 1ps
`default_nettype none
module multi_key_row_comparator
	import mkrc_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// left_key_a..d then right_key_a..d, 64 bits each, from bit 0 up
	input  wire logic [8*KEY_W-1:0]       s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// left_first [0], all_equal [1], deciding_key [3:2], zeros [7:4]
	output logic [7:0]                    m_axis_tdata,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);
	logic [11:0] types_q;
	logic [3:0]  desc_q;
	logic [2:0]  count_q;
	logic [2:0]  count_eff;
	lane_res_t [MAX_KEYS-1:0] lanes;
	logic lf, ae;
	logic [1:0] dk;
	logic [3:0] res_q;
	logic valid_q;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !valid_q || m_axis_tready;
	assign count_eff = (count_q > 3'(MAX_KEYS)) ? 3'(MAX_KEYS) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q <= '0;
			desc_q <= '0;
			count_q <= 3'd1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TYPES: types_q <= cfg_data;
				CFG_DESC:  desc_q <= cfg_data[3:0];
				CFG_COUNT: count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < MAX_KEYS; k++) begin : g_lane
		mkrc_lane u_lane (
			.key_type(types_q[3*k +: 3]),
			.l(s_axis_tdata[k*KEY_W +: KEY_W]),
			.r(s_axis_tdata[(4+k)*KEY_W +: KEY_W]),
			.res(lanes[k])
		);
	end

	mkrc_merge #(.MAX_KEYS(MAX_KEYS)) u_merge (
		.lanes(lanes),
		.key_count(count_eff),
		.key_desc(desc_q),
		.left_first(lf),
		.all_equal(ae),
		.deciding_key(dk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			res_q <= {dk, ae, lf};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {4'd0, res_q};
endmodule
`default_nettype wire

// File: design/mkrc_lane.sv
// One comparison lane: orders a single key pair by its configured type.
// Depends on mkrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mkrc_lane
	import mkrc_pkg::*;
(
	input  wire logic [2:0]       key_type,
	input  wire logic [KEY_W-1:0] l,
	input  wire logic [KEY_W-1:0] r,
	output lane_res_t             res
);
	logic [KEY_W-1:0] lk, rk;
	logic is_f, nan_any, both_zero;

	// Map each type onto an unsigned key so that one magnitude compare orders it.
	function automatic logic [KEY_W-1:0] map_key(input logic [2:0] t, input logic [KEY_W-1:0] v);
		logic [KEY_W-1:0] m;
		m = '0;
		unique case (key_type_t'(t))
			KT_I32: m = {32'd0, v[31] ^ 1'b1, v[30:0]};
			KT_U32: m = {32'd0, v[31:0]};
			KT_I64: m = {v[63] ^ 1'b1, v[62:0]};
			KT_U64: m = v;
			KT_F32: m = v[31] ? {32'd0, ~v[31:0]} : {32'd0, 1'b1, v[30:0]};
			KT_F64: m = v[63] ? ~v : {1'b1, v[62:0]};
			KT_VTX: m = {24'd0, v[39:0]};
			KT_RAW: m = v;
			default: m = v;
		endcase
		return m;
	endfunction

	always_comb begin
		lk = map_key(key_type, l);
		rk = map_key(key_type, r);
		is_f = (key_type == KT_F32) || (key_type == KT_F64);
		if (key_type == KT_F32) begin
			nan_any = (&l[30:23] && |l[22:0]) || (&r[30:23] && |r[22:0]);
			both_zero = (l[30:0] == '0) && (r[30:0] == '0);
		end else begin
			nan_any = (&l[62:52] && |l[51:0]) || (&r[62:52] && |r[51:0]);
			both_zero = (l[62:0] == '0) && (r[62:0] == '0);
		end
		if (is_f && (nan_any || both_zero)) begin
			res.lt = 1'b0;
			res.gt = 1'b0;
		end else begin
			res.lt = lk < rk;
			res.gt = lk > rk;
		end
	end
endmodule
`default_nettype wire

// File: design/mkrc_merge.sv
// Merge stage: picks the first lane in use that differs and forms the answer.
// Depends on mkrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mkrc_merge
	import mkrc_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS
) (
	input  wire lane_res_t [MAX_KEYS-1:0] lanes,
	input  wire logic [2:0]               key_count,
	input  wire logic [3:0]               key_desc,
	output logic                          left_first,
	output logic                          all_equal,
	output logic [1:0]                    deciding_key
);
	always_comb begin
		left_first = 1'b0;
		all_equal = 1'b1;
		deciding_key = 2'd0;
		for (int k = MAX_KEYS - 1; k >= 0; k--) begin
			if ((3'(k) < key_count) && (lanes[k].lt || lanes[k].gt)) begin
				left_first = key_desc[k] ? lanes[k].gt : lanes[k].lt;
				all_equal = 1'b0;
				deciding_key = 2'(k);
			end
		end
	end
endmodule
`default_nettype wire

// File: design/mkrc_checker.sv
// Port-level checker for the multi-key row comparator, bound to the top level.
// Depends on mkrc_pkg and multi_key_row_comparator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_row_comparator_assert.svh"
module mkrc_checker
	import mkrc_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);
	`MKRC_ASSERT_IMP(a_eq_no_first, clk, arst_n, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0] && m_axis_tdata[3:2] == 2'd0, "all-equal result claims an order")
	`MKRC_ASSERT_NEXT(a_in_gives_out, clk, arst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted pair produced no result")
	`MKRC_ASSERT_IMP(a_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
	`MKRC_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind multi_key_row_comparator mkrc_checker u_mkrc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of the multi-key row comparator.
// Depends on mkrc_pkg and multi_key_row_comparator; a predictor of key ordering
// inside a small scoreboard class checks every result transfer.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import mkrc_pkg::*;

	typedef struct {
		bit       left_first;
		bit       all_equal;
		bit [1:0] deciding_key;
	} order_t;

	class order_scoreboard;
		bit [11:0] types;
		bit [3:0]  descending;
		bit [2:0]  count;
		order_t    pending_orders[$];
		int        errors;

		function new();
			types = 0;
			descending = 0;
			count = 1;
			errors = 0;
		endfunction

		// Orders two IEEE values by their bits; NaN and signed zeros tie.
		static function int float_order(bit [63:0] l, bit [63:0] r, bit dbl);
			bit [63:0] lk;
			bit [63:0] rk;
			bit        l_nan;
			bit        r_nan;
			if (dbl) begin
				l_nan = &l[62:52] && |l[51:0];
				r_nan = &r[62:52] && |r[51:0];
				if (l_nan || r_nan || (l[62:0] == 0 && r[62:0] == 0))
					return 0;
				lk = l[63] ? ~l : (l | 64'h8000_0000_0000_0000);
				rk = r[63] ? ~r : (r | 64'h8000_0000_0000_0000);
			end else begin
				l_nan = &l[30:23] && |l[22:0];
				r_nan = &r[30:23] && |r[22:0];
				if (l_nan || r_nan || (l[30:0] == 0 && r[30:0] == 0))
					return 0;
				lk = {32'd0, l[31] ? ~l[31:0] : (l[31:0] | 32'h8000_0000)};
				rk = {32'd0, r[31] ? ~r[31:0] : (r[31:0] | 32'h8000_0000)};
			end
			return (lk < rk) ? -1 : (lk > rk) ? 1 : 0;
		endfunction

		static function int key_order(key_type_t kt, bit [63:0] l, bit [63:0] r);
			bit [63:0] lk;
			bit [63:0] rk;
			case (kt)
				KT_I32: begin
					lk = {32'd0, l[31:0] ^ 32'h8000_0000};
					rk = {32'd0, r[31:0] ^ 32'h8000_0000};
				end
				KT_U32: begin
					lk = {32'd0, l[31:0]};
					rk = {32'd0, r[31:0]};
				end
				KT_I64: begin
					lk = l ^ 64'h8000_0000_0000_0000;
					rk = r ^ 64'h8000_0000_0000_0000;
				end
				KT_F32: return float_order(l, r, 1'b0);
				KT_F64: return float_order(l, r, 1'b1);
				KT_VTX: begin
					lk = {24'd0, l[39:0]};
					rk = {24'd0, r[39:0]};
				end
				default: begin
					lk = l;
					rk = r;
				end
			endcase
			return (lk < rk) ? -1 : (lk > rk) ? 1 : 0;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [11:0] value);
			case (idx)
				CFG_TYPES: types = value;
				CFG_DESC:  descending = value[3:0];
				CFG_COUNT: count = value[2:0];
				default: ;
			endcase
		endfunction

		function void note_pair(bit [8*KEY_W-1:0] row_pair);
			order_t    o;
			int        used;
			int        c;
			key_type_t kt;
			used = (count > 4) ? 4 : count;
			o.left_first = 0;
			o.all_equal = 1;
			o.deciding_key = 0;
			for (int k = 0; k < used; k++) begin
				kt = key_type_t'(types[3*k +: 3]);
				c = key_order(kt, row_pair[64*k +: 64], row_pair[64*(k+4) +: 64]);
				if (c != 0) begin
					o.left_first = descending[k] ? (c > 0) : (c < 0);
					o.all_equal = 0;
					o.deciding_key = 2'(k);
					break;
				end
			end
			pending_orders.push_back(o);
		endfunction

		function void check_result(bit [7:0] data);
			order_t o;
			if (pending_orders.size() == 0) begin
				$error("result 0x%0h arrived with nothing expected", data);
				errors++;
				return;
			end
			o = pending_orders.pop_front();
			if (data[0] != o.left_first) begin
				$error("left_first: expected %0d, actual %0d", o.left_first, data[0]);
				errors++;
			end
			if (data[1] != o.all_equal) begin
				$error("all_equal: expected %0d, actual %0d", o.all_equal, data[1]);
				errors++;
			end
			if (data[3:2] != o.deciding_key) begin
				$error("deciding_key: expected %0d, actual %0d", o.deciding_key, data[3:2]);
				errors++;
			end
			if (data[7:4] != 0) begin
				$error("padding: expected 0, actual %0d", data[7:4]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [8*KEY_W-1:0]     s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [7:0]             m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	order_scoreboard sb = new();
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;

	multi_key_row_comparator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// The receiver decides its ready at each edge; a long hold-off overrides it.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Outputs are stable mid-cycle, so a transfer is seen at the falling edge before it.
	always @(negedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	task automatic write_cfg(cfg_reg_t idx, bit [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		sb.write_reg(idx, value);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pair(bit [8*KEY_W-1:0] row_pair);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= row_pair;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		sb.note_pair(row_pair);
	endtask

	task automatic drain();
		int unsigned waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.pending_orders.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(bit [11:0] types, bit [3:0] desc, bit [2:0] count);
		drain();
		write_cfg(CFG_TYPES, types);
		write_cfg(CFG_DESC, {8'd0, desc});
		write_cfg(CFG_COUNT, {9'd0, count});
	endtask

	function automatic bit [63:0] special_key();
		case ($urandom_range(11))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h0000_0000_8000_0000;
			4: return 64'h0000_0000_7FFF_FFFF;
			5: return 64'h0000_0000_7FC0_0000;
			6: return 64'h7FF8_0000_0000_0001;
			7: return 64'h0000_0000_7F80_0000;
			8: return 64'hFFF0_0000_0000_0000;
			9: return 64'h7FFF_FFFF_FFFF_FFFF;
			10: return 64'h0000_00FF_FFFF_FFFF;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Most keys tie or differ in a single bit so that later keys get to decide.
	function automatic bit [8*KEY_W-1:0] random_pair();
		bit [8*KEY_W-1:0] p;
		bit [63:0]        l;
		bit [63:0]        r;
		for (int k = 0; k < 4; k++) begin
			l = ($urandom_range(3) == 0) ? special_key() : {$urandom, $urandom};
			case ($urandom_range(9))
				0, 1, 2, 3: r = l;
				4, 5: r = l ^ (64'd1 << $urandom_range(63));
				6: r = special_key();
				default: r = {$urandom, $urandom};
			endcase
			if ($urandom_range(1)) begin
				p[64*k +: 64] = l;
				p[64*(k+4) +: 64] = r;
			end else begin
				p[64*k +: 64] = r;
				p[64*(k+4) +: 64] = l;
			end
		end
		return p;
	endfunction

	function automatic bit [8*KEY_W-1:0] row_of(bit [63:0] l, bit [63:0] r);
		return {r, r, r, r, l, l, l, l};
	endfunction

	initial begin
		bit [11:0] types;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset configuration: one signed 32-bit ascending key.
		send_pair(row_of(64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF));

		// Directed: every key type alike on all four keys, with the extremes,
		// NaN against a number, and minus zero against plus zero.
		for (int t = 0; t < 8; t++) begin
			types = {4{t[2:0]}};
			configure(types, t[0] ? 4'hF : 4'h0, 3'd4);
			send_pair(row_of(64'd0, '1));
			send_pair(row_of(64'hFFF8_0000_7FC0_0000, 64'h3FF0_0000_3F80_0000));
			send_pair({64'd1, 64'd0, 64'd0, 64'h8000_0000_8000_0000,
				64'd2, 64'd0, 64'd0, 64'd0});
		end

		// Random phases; the first two use the extreme settings and the last
		// ones clamp or drop the key count.
		for (int ph = 0; ph < 10; ph++) begin
			tx_idle_pct = (ph < 3) ? 18 : (ph < 6) ? 47 : 0;
			rx_idle_pct = (ph < 3) ? 47 : (ph < 6) ? 18 : 0;
			case (ph)
				0: configure(12'h000, 4'h0, 3'd1);
				1: configure(12'hFFF, 4'hF, 3'd4);
				8: configure(12'($urandom_range(4095)), 4'($urandom_range(15)), 3'd7);
				9: configure(12'($urandom_range(4095)), 4'($urandom_range(15)), 3'd0);
				default: configure(12'($urandom_range(4095)), 4'($urandom_range(15)),
					3'($urandom_range(1, 5)));
			endcase
			for (int i = 0; i < 48; i++) begin
				if (ph == 7 && i == 10)
					hold_request = 300;
				if (ph == 4 && i == 24)
					drain();
				send_pair(random_pair());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_orders.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
